// File: hdl/kclp_pkg.sv
// Package with shared types and constants of the keyed count line parser.
package kclp_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_LERR  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_VALID  = 2'd1,
    OUT_REJECT = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SKIP   = 3'd1,
    PH_SIGN   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4,
    PH_FAIL   = 3'd5
  } phase_e;

  localparam int unsigned NUM_KEYS = 5;
  localparam int unsigned KEY_MAX  = 17;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [16:0] MAG_SAT = 17'd65536;

  localparam logic [4:0] KEY_LEN [NUM_KEYS] = '{5'd16, 5'd17, 5'd8, 5'd9, 5'd9};

  // Key texts, character 0 first, padded with zero.
  localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_MAX] = '{
    '{8'h22, 8'h63, 8'h6d, 8'h64, 8'h22, 8'h3a, 8'h22, 8'h41, 8'h49, 8'h5f,
      8'h46, 8'h52, 8'h55, 8'h49, 8'h54, 8'h22, 8'h00},
    '{8'h22, 8'h63, 8'h6d, 8'h64, 8'h22, 8'h3a, 8'h20, 8'h22, 8'h41, 8'h49,
      8'h5f, 8'h46, 8'h52, 8'h55, 8'h49, 8'h54, 8'h22},
    '{8'h22, 8'h61, 8'h70, 8'h70, 8'h6c, 8'h65, 8'h22, 8'h3a, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h22, 8'h62, 8'h61, 8'h6e, 8'h61, 8'h6e, 8'h61, 8'h22, 8'h3a, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h22, 8'h6f, 8'h72, 8'h61, 8'h6e, 8'h67, 8'h65, 8'h22, 8'h3a, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Failure-function step of a key matcher: longest prefix of the key that
  // ends the matched text plus the new byte. The matched text is always a
  // prefix of the key, so every candidate test compares key bytes with key
  // bytes and only the new byte is a live input.
  function automatic logic [4:0] match_next(input int unsigned k, input logic [4:0] m,
                                            input logic [7:0] c);
    logic [4:0] r;
    logic       hit;
    r = 5'd0;
    hit = 1'b0;
    if (m >= KEY_LEN[k]) begin
      r = KEY_LEN[k];
    end else begin
      for (int cand = 1; cand <= int'(KEY_MAX); cand++) begin
        if (cand <= int'(m) + 1) begin
          hit = (KEY_TEXT[k][cand-1] == c);
          for (int j = 0; j < int'(KEY_MAX) - 1; j++) begin
            if (j < cand - 1 &&
                KEY_TEXT[k][int'(m) - cand + 1 + j] != KEY_TEXT[k][j]) hit = 1'b0;
          end
          if (hit) r = 5'(cand);
        end
      end
    end
    return r;
  endfunction

  typedef struct packed {
    phase_e      phase;
    logic        neg;
    logic [16:0] mag;
  } num_t;

  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    logic        online;
    outcome_e    outcome;
  } result_t;

endpackage

// File: hdl/kclp_if.sv
// Valid/ready channel interfaces for the input items and the results.
interface kclp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface kclp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_count;
  logic [15:0] second_count;
  logic [15:0] third_count;
  logic        online;
  logic [1:0]  line_outcome;
  modport source (output valid, output first_count, output second_count,
                  output third_count, output online, output line_outcome, input ready);
  modport sink (input valid, input first_count, input second_count,
                input third_count, input online, input line_outcome, output ready);
endinterface

// File: hdl/kclp_num.sv
// One signed decimal number parser step.
module kclp_num (
  input  kclp_pkg::num_t   cur_i,
  input  logic [7:0]       byte_i,
  output kclp_pkg::num_t   nxt_o
);
  import kclp_pkg::*;
  logic        digit;
  logic        ws;
  logic [16:0] d;
  logic [20:0] prod;

  always_comb begin
    digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
    ws = (byte_i == 8'h20) || (byte_i == 8'h09) || (byte_i == 8'h0b) ||
         (byte_i == 8'h0c) || (byte_i == 8'h0a) || (byte_i == 8'h0d);
    d = digit ? {13'd0, byte_i[3:0]} : 17'd0;
    prod = {cur_i.mag, 3'b000} + {2'b00, cur_i.mag, 1'b0} + {4'd0, d};
    nxt_o = cur_i;
    case (cur_i.phase)
      PH_SKIP: begin
        if (ws) begin
        end else if (byte_i == 8'h2b || byte_i == 8'h2d) begin
          nxt_o.neg = (byte_i == 8'h2d);
          nxt_o.phase = PH_SIGN;
        end else if (digit) begin
          nxt_o.mag = d;
          nxt_o.phase = PH_DIGITS;
        end else begin
          nxt_o.phase = PH_FAIL;
        end
      end
      PH_SIGN: begin
        if (digit) begin
          nxt_o.mag = d;
          nxt_o.phase = PH_DIGITS;
        end else begin
          nxt_o.phase = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          nxt_o.mag = (prod > {4'd0, MAG_SAT}) ? MAG_SAT : prod[16:0];
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

// File: hdl/keyed_count_line_parser.sv
// Top level of the keyed count line parser.
// The parser takes one item per cycle: a received byte, a millisecond tick
// or a line-error event, and returns exactly one result for each item
// through an output register that a stalled sink can hold while a skid
// register keeps the next result, so a new item is taken every cycle the
// sink keeps up. Every byte updates five key matchers and three number
// parsers together; at LF the line is judged and, when the command key and
// all three counts were found, the counts are published and the block goes
// online. Online clears once timeout_ticks ticks pass without a valid line.
// Lines longer than LINE_CAPACITY-1 bytes are dropped.
module keyed_count_line_parser #(
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  kclp_in_if.sink     in_ch,
  kclp_out_if.source  out_ch
);
  import kclp_pkg::*;

  localparam int unsigned LW = $clog2(LINE_CAPACITY);

  logic [15:0]  timeout_q;
  logic [LW-1:0] len_q, len_d;
  logic         nul_q, nul_d;
  logic [4:0]   prog_q [NUM_KEYS];
  logic [4:0]   prog_d [NUM_KEYS];
  num_t         num_q [3];
  num_t         num_d [3];
  num_t         num_step [3];
  logic [15:0]  cnt_q [3];
  logic [15:0]  cnt_d [3];
  logic         online_q, online_d;
  logic [15:0]  ticks_q, ticks_d;
  outcome_e     outcome;

  // Output register plus skid register.
  result_t      res_q, skid_q, res_new;
  logic         res_vld_q, skid_vld_q;
  logic         take;

  assign in_ch.ready = !skid_vld_q;
  assign take = in_ch.valid && in_ch.ready;

  for (genvar g = 0; g < 3; g++) begin : g_num
    kclp_num u_num (.cur_i(num_q[g]), .byte_i(in_ch.rx_byte), .nxt_o(num_step[g]));
  end

  always_comb begin
    logic ok;
    len_d = len_q;
    nul_d = nul_q;
    prog_d = prog_q;
    num_d = num_q;
    cnt_d = cnt_q;
    online_d = online_q;
    ticks_d = ticks_q;
    outcome = OUT_NONE;
    ok = 1'b0;
    case (cmd_e'(in_ch.command))
      CMD_BYTE: begin
        if (in_ch.rx_byte == 8'h0a) begin
          if (len_q != '0) begin
            ok = (prog_q[0] >= KEY_LEN[0]) || (prog_q[1] >= KEY_LEN[1]);
            for (int i = 0; i < 3; i++) begin
              if (num_q[i].phase != PH_DIGITS && num_q[i].phase != PH_DONE) ok = 1'b0;
            end
            if (ok) begin
              for (int i = 0; i < 3; i++) begin
                cnt_d[i] = num_q[i].neg ? 16'd0 :
                           (num_q[i].mag[16] ? 16'hffff : num_q[i].mag[15:0]);
              end
              online_d = 1'b1;
              ticks_d = '0;
              outcome = OUT_VALID;
            end else begin
              outcome = OUT_REJECT;
            end
          end
          len_d = '0;
          nul_d = 1'b0;
          for (int k = 0; k < NUM_KEYS; k++) prog_d[k] = '0;
          for (int i = 0; i < 3; i++) num_d[i] = '{PH_IDLE, 1'b0, 17'd0};
        end else if (in_ch.rx_byte != 8'h0d) begin
          if (len_q < LW'(LINE_CAPACITY - 1)) begin
            len_d = len_q + 1'b1;
            if (in_ch.rx_byte == 8'h00) nul_d = 1'b1;
            if (!nul_q && in_ch.rx_byte != 8'h00) begin
              for (int k = 0; k < NUM_KEYS; k++) begin
                if (k >= 2) num_d[k-2] = num_step[k-2];
                if (prog_q[k] < KEY_LEN[k]) begin
                  prog_d[k] = match_next(k, prog_q[k], in_ch.rx_byte);
                  if (k >= 2 && prog_d[k] >= KEY_LEN[k]) num_d[k-2].phase = PH_SKIP;
                end
              end
            end
          end else begin
            len_d = '0;
            nul_d = 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) prog_d[k] = '0;
            for (int i = 0; i < 3; i++) num_d[i] = '{PH_IDLE, 1'b0, 17'd0};
          end
        end
      end
      CMD_TICK: begin
        if (ticks_q != 16'hffff) ticks_d = ticks_q + 16'd1;
        if (online_q && ticks_d >= timeout_q) online_d = 1'b0;
      end
      CMD_LERR: begin
        len_d = '0;
        nul_d = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) prog_d[k] = '0;
        for (int i = 0; i < 3; i++) num_d[i] = '{PH_IDLE, 1'b0, 17'd0};
      end
      default: begin
      end
    endcase
    res_new = '{cnt_d[0], cnt_d[1], cnt_d[2], online_d, outcome};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      len_q <= '0;
      nul_q <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) prog_q[k] <= '0;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= '{PH_IDLE, 1'b0, 17'd0};
        cnt_q[i] <= '0;
      end
      online_q <= 1'b0;
      ticks_q <= '0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (take) begin
        len_q <= len_d;
        nul_q <= nul_d;
        prog_q <= prog_d;
        num_q <= num_d;
        cnt_q <= cnt_d;
        online_q <= online_d;
        ticks_q <= ticks_d;
      end
    end
  end

  // Result delivery: the skid register fills only when the output register
  // is stalled and a new transfer comes in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!res_vld_q || out_ch.ready) begin
        res_vld_q <= skid_vld_q || take;
        skid_vld_q <= 1'b0;
      end else if (take) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!res_vld_q || out_ch.ready) begin
      res_q <= skid_vld_q ? skid_q : res_new;
    end else if (take) begin
      skid_q <= res_new;
    end
  end

  assign out_ch.valid = res_vld_q;
  assign out_ch.first_count = res_q.c0;
  assign out_ch.second_count = res_q.c1;
  assign out_ch.third_count = res_q.c2;
  assign out_ch.online = res_q.online;
  assign out_ch.line_outcome = res_q.outcome;

  // The skid register only holds a result while the output register does.
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> res_vld_q) else $error("skid full with empty output");

  // In the cycle after a transfer the output register always holds a result.
  a_take_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> res_vld_q) else $error("transfer lost its result");

  // The line length never reaches the capacity.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q < LW'(LINE_CAPACITY - 1) || len_q == LW'(LINE_CAPACITY - 1))
    else $error("line length overflow");

endmodule

// File: verif/keyed_count_line_parser_tb.sv
// Self-checking testbench for the keyed count line parser.
`timescale 1ns / 100ps

module testbench;
  import kclp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  kclp_in_if in_ch ();
  kclp_out_if out_ch ();

  keyed_count_line_parser #(.LINE_CAPACITY(128)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Reference state of the parser, kept in step with every accepted transfer.
  logic [15:0] timeout_ticks;
  int unsigned line_len;
  logic [4:0] key_prog [NUM_KEYS];
  phase_e num_phase [3];
  logic num_neg [3];
  int unsigned num_mag [3];
  logic [15:0] counts [3];
  logic is_online;
  logic [15:0] ticks_idle;
  logic nul_hit;

  result_t expected_results [$];
  int errors = 0;
  longint cycles = 0;
  int stall_mode = 0;

  // Command value of the command key, as ASCII bytes.
  localparam logic [63:0] CMD_WORD = 64'h41495f4652554954;
  string cmd_word;
  string cmd_a;
  string cmd_b;
  string key_str [NUM_KEYS];

  function automatic void clear_line_state();
    line_len = 0;
    nul_hit = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) key_prog[i] = '0;
    for (int i = 0; i < 3; i++) begin
      num_phase[i] = PH_IDLE;
      num_neg[i] = 1'b0;
      num_mag[i] = 0;
    end
  endfunction

  // Generic prefix-function step: longest key prefix ending the text plus c.
  function automatic logic [4:0] key_step(int k, int m, byte unsigned c);
    string s;
    int n;
    bit ok;
    s = key_str[k];
    n = s.len();
    if (m >= n) return n[4:0];
    for (int cand = m + 1; cand >= 1; cand--) begin
      ok = (s[cand-1] == c);
      for (int j = 0; ok && j < cand - 1; j++)
        if (s[j] != s[m - cand + 1 + j]) ok = 0;
      if (ok) return cand[4:0];
    end
    return 5'd0;
  endfunction

  function automatic void feed_number(int i, byte unsigned c);
    bit digit;
    bit ws;
    digit = (c >= 8'h30 && c <= 8'h39);
    ws = (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0A || c == 8'h0D);
    case (num_phase[i])
      PH_SKIP: begin
        if (ws) begin
        end else if (c == 8'h2B || c == 8'h2D) begin
          num_neg[i] = (c == 8'h2D);
          num_phase[i] = PH_SIGN;
        end else if (digit) begin
          num_mag[i] = c - 8'h30;
          num_phase[i] = PH_DIGITS;
        end else begin
          num_phase[i] = PH_FAIL;
        end
      end
      PH_SIGN: begin
        if (digit) begin
          num_mag[i] = c - 8'h30;
          num_phase[i] = PH_DIGITS;
        end else begin
          num_phase[i] = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          num_mag[i] = num_mag[i] * 10 + (c - 8'h30);
          if (num_mag[i] > 65536) num_mag[i] = 65536;
        end else begin
          num_phase[i] = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic outcome_e judge_line();
    bit ok;
    ok = (key_prog[0] >= KEY_LEN[0]) || (key_prog[1] >= KEY_LEN[1]);
    for (int i = 0; i < 3; i++)
      if (num_phase[i] != PH_DIGITS && num_phase[i] != PH_DONE) ok = 0;
    if (ok) begin
      for (int i = 0; i < 3; i++)
        counts[i] = num_neg[i] ? 16'd0 : (num_mag[i] > 65535 ? 16'hFFFF : num_mag[i][15:0]);
      is_online = 1'b1;
      ticks_idle = '0;
      return OUT_VALID;
    end
    return OUT_REJECT;
  endfunction

  // Advances the reference state by one item and queues the result it causes.
  function automatic void predict_parser(cmd_e cmd, byte unsigned c);
    outcome_e oc;
    bit found;
    result_t r;
    oc = OUT_NONE;
    case (cmd)
      CMD_BYTE: begin
        if (c == 8'h0A) begin
          if (line_len > 0) oc = judge_line();
          clear_line_state();
        end else if (c != 8'h0D) begin
          if (line_len < 127) begin
            line_len++;
            if (c == 8'h00) nul_hit = 1'b1;
            if (!nul_hit) begin
              for (int i = 0; i < NUM_KEYS; i++) begin
                found = key_prog[i] >= KEY_LEN[i];
                if (i >= 2) feed_number(i - 2, c);
                if (!found) begin
                  key_prog[i] = key_step(i, key_prog[i], c);
                  if (i >= 2 && key_prog[i] >= KEY_LEN[i]) num_phase[i-2] = PH_SKIP;
                end
              end
            end
          end else begin
            clear_line_state();
          end
        end
      end
      CMD_TICK: begin
        if (ticks_idle != 16'hFFFF) ticks_idle++;
        if (is_online && ticks_idle >= timeout_ticks) is_online = 1'b0;
      end
      CMD_LERR: clear_line_state();
      default: begin
      end
    endcase
    r.c0 = counts[0];
    r.c1 = counts[1];
    r.c2 = counts[2];
    r.online = is_online;
    r.outcome = oc;
    expected_results.push_back(r);
  endfunction

  // Sends one item; the sender works in bursts with random idle gaps.
  int burst_left = 0;
  task automatic send_item(cmd_e cmd, byte unsigned c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_parser(cmd, c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i]);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    timeout_ticks = v;
  endtask

  // Receiver stall pattern: changes its mode now and then, sometimes never stalls.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default: out_ch.ready <= (cycles % 7) < 3;
    endcase
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    result_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result c=%h/%h/%h online=%b outcome=%0d", $time,
                 out_ch.first_count, out_ch.second_count, out_ch.third_count,
                 out_ch.online, out_ch.line_outcome);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.first_count !== e.c0 || out_ch.second_count !== e.c1 ||
            out_ch.third_count !== e.c2 || out_ch.online !== e.online ||
            out_ch.line_outcome !== e.outcome) begin
          $display({"%0t: mismatch expected %h/%h/%h online=%b outcome=%0d, ",
                    "got %h/%h/%h online=%b outcome=%0d"},
                   $time, e.c0, e.c1, e.c2, e.online, e.outcome,
                   out_ch.first_count, out_ch.second_count, out_ch.third_count,
                   out_ch.online, out_ch.line_outcome);
          errors++;
        end
      end
    end
  end

  // Global timeout.
  always @(posedge clk_i) begin
    if (cycles > 50000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic string rand_number();
    case ($urandom_range(0, 5))
      0: return $sformatf("%0d", $urandom_range(0, 65535));
      1: return $sformatf("-%0d", $urandom_range(0, 99999));
      2: return $sformatf("+%0d", $urandom_range(0, 9));
      3: return $sformatf("%0d", $urandom_range(65536, 999999));
      4: return " \t 42";
      default: return (($urandom_range(0, 1) != 0) ? "-" : "x");
    endcase
  endfunction

  function automatic string rand_line();
    string s;
    string f [4];
    f[0] = ($urandom_range(0, 1) != 0) ? cmd_a : cmd_b;
    if ($urandom_range(0, 9) == 0) f[0] = {"\"cmd\":\"", cmd_word.substr(0, 5), "\""};
    f[1] = {"\"apple\":", rand_number()};
    f[2] = {"\"banana\":", rand_number()};
    f[3] = {"\"orange\":", rand_number()};
    if ($urandom_range(0, 9) == 0) f[$urandom_range(0, 3)] = "\"x\":1";
    for (int i = 3; i > 0; i--) begin
      int j;
      string t;
      j = $urandom_range(0, i);
      t = f[i]; f[i] = f[j]; f[j] = t;
    end
    s = {"{", f[0], ",", f[1], ",", f[2], ",", f[3], "}"};
    if ($urandom_range(0, 5) == 0) s = {s, "\r"};
    return s;
  endfunction

  // Directed lines: both command forms, extremes, NUL, CR, empty, error, bad code.
  task automatic test_directed_lines();
    send_text({"{", cmd_a, ",\"apple\":65535,\"banana\":0,\"orange\":-5}\n"});
    send_text({cmd_b, "\"apple\": 99999\"banana\":+7\r\"orange\":1\n"});
    send_text("\n");
    send_text({cmd_a, "\"apple\":1\"banana\":2\"orange\":3"});
    send_item(CMD_BYTE, 8'h00);
    send_text("\"x\n");
    send_text("\"apple\":1");
    send_item(CMD_LERR, 8'hFF);
    send_item(CMD_NONE, 8'hA5);
    send_text("\"apple\":x\n");
  endtask

  // Over-long line is discarded; framing restarts after the dropped byte.
  task automatic test_long_line();
    for (int i = 0; i < 128; i++) send_item(CMD_BYTE, 8'h80 | i[6:0]);
    send_text({cmd_a, "\"apple\":4\"banana\":5\"orange\":6\n"});
  endtask

  // Ticks with small and extreme timeouts.
  task automatic test_timeout();
    write_timeout(16'd0);
    send_text({cmd_a, "\"apple\":1\"banana\":1\"orange\":1\n"});
    send_item(CMD_TICK, 8'h00);
    write_timeout(16'd3);
    send_text({cmd_a, "\"apple\":2\"banana\":2\"orange\":2\n"});
    repeat (4) send_item(CMD_TICK, 8'h00);
    write_timeout(16'hFFFF);
    send_text({cmd_a, "\"apple\":3\"banana\":3\"orange\":3\n"});
    repeat (20) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed lines with random content, plus noise and ticks.
  task automatic test_random_traffic();
    int sent;
    int n;
    string s;
    sent = 0;
    while (sent < 80) begin
      if (sent > 40 && sent < 50) write_timeout(16'($urandom_range(1, 40)));
      case ($urandom_range(0, 9))
        0: begin
          send_item(cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          sent++;
        end
        1, 2: begin
          n = $urandom_range(1, 15);
          repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
          sent += n;
        end
        default: begin
          s = rand_line();
          if ($urandom_range(0, 19) == 0) s = s.substr(0, s.len() / 2);
          send_text(s);
          if ($urandom_range(0, 15) == 0) send_item(CMD_LERR, 8'h00);
          else send_item(CMD_BYTE, 8'h0A);
          sent += s.len() + 1;
        end
      endcase
    end
  endtask

  initial begin
    cmd_word = $sformatf("%s", CMD_WORD);
    cmd_a = {"\"cmd\":\"", cmd_word, "\""};
    cmd_b = {"\"cmd\": \"", cmd_word, "\""};
    key_str = '{cmd_a, cmd_b, "\"apple\":", "\"banana\":", "\"orange\":"};
    in_ch.valid = 1'b0;
    in_ch.command = CMD_NONE;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    timeout_ticks = TIMEOUT_RESET;
    clear_line_state();
    for (int i = 0; i < 3; i++) counts[i] = '0;
    is_online = 1'b0;
    ticks_idle = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_long_line();
    wait_drained();
    test_timeout();
    test_random_traffic();
    write_timeout(TIMEOUT_RESET);
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
